>>> hw/rtl/stsin_pkg.sv
// ----------------------------------------------------------------------------
// stsin_pkg
// Shared widths, codes and control types for the series sine unit.
// ----------------------------------------------------------------------------
`default_nettype none

package stsin_pkg;

    localparam int FRACTION_BITS   = 28;
    localparam int MAX_STEPS_LIMIT = 32;

    localparam int ANGLE_W    = 32;
    localparam int TOL_W      = 32;
    localparam int MAXS_W     = 6;
    localparam int SINE_W     = 40;
    localparam int TERMS_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int CAP_BIT = 62;
    localparam int SUM_W   = CAP_BIT + 2;
    localparam int MAG_W   = CAP_BIT + 1;
    localparam int X2_W    = 2 * ANGLE_W - 1 - FRACTION_BITS;
    localparam int PROD_W  = MAG_W + X2_W;
    localparam int DVD_W   = PROD_W - FRACTION_BITS;
    localparam int STEP_W  = $clog2(MAX_STEPS_LIMIT + 1);
    localparam int K_W     = STEP_W + 1;
    localparam int KK_W    = 2 * K_W;
    localparam int CNT_W   = $clog2(DVD_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = CFG_IDX_W'(1);

    localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(268);
    localparam logic [MAXS_W-1:0] MAXS_RESET = MAXS_W'(10);

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } mdu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mdu_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/sine_taylor_series_unit.sv
// ----------------------------------------------------------------------------
// sine_taylor_series_unit
// Sine of a fixed point angle by its Maclaurin series.
//
// Input: pulse start with angle (signed, 28 fraction bits) while busy is
// low; the beat is taken at that edge and busy rises on the next cycle.
// Output: done is high for one cycle with sine_value (signed, 28 fraction
// bits, saturated to 40 bits) and terms_used. The receiver cannot stall.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the
// tolerance, index 1 is max_steps, other indexes are dropped. cfg_ready is
// always high; write only while busy is low.
// Sequence: one serial multiply/divide unit does all the work. It first
// squares the angle; each series step is then a multiply, a divide and
// bookkeeping. At most 32 steps are taken for an angle; one angle is in
// flight at a time. Reset loads tolerance 268 and max_steps 10 and idles.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_taylor_series_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [stsin_pkg::ANGLE_W-1:0] angle,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [stsin_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [stsin_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                   done,
    output logic signed [stsin_pkg::SINE_W-1:0]    sine_value,
    output logic [stsin_pkg::TERMS_W-1:0]          terms_used
);
    import stsin_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQR   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    localparam logic signed [SUM_W:0] CAP_POS = signed'((SUM_W + 1)'(1) << CAP_BIT);
    localparam logic signed [SUM_W:0] CAP_NEG = -CAP_POS;

    logic [2:0]                state_reg, state_next;
    logic [TOL_W-1:0]          tol_reg, tol_next;
    logic [MAXS_W-1:0]         maxs_reg, maxs_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [SUM_W-1:0]   prev_reg, prev_next;
    logic signed [SUM_W-1:0]   term_reg, term_next;
    logic [X2_W-1:0]           x2_reg, x2_next;
    logic [STEP_W-1:0]         steps_reg, steps_next;
    logic [KK_W-1:0]           kk_reg, kk_next;
    logic                      done_reg, done_next;
    logic signed [SINE_W-1:0]  sine_reg, sine_next;
    logic [TERMS_W-1:0]        terms_reg, terms_next;

    mdu_cmd_t                  cmd;
    mdu_stat_t                 stat;
    logic [MAG_W-1:0]          mcand;
    logic [X2_W-1:0]           mplier;
    logic [PROD_W-1:0]         mdu_result;

    logic                      accept;
    logic [ANGLE_W-1:0]        angle_mag;
    logic [STEP_W-1:0]         limit;
    logic signed [SUM_W:0]     diff;
    logic [SUM_W:0]            diff_mag;
    logic                      go_on;
    logic [K_W-1:0]            k_new;
    logic [MAG_W-1:0]          term_mag;
    logic [SUM_W-SINE_W:0]     sum_top;
    logic [DVD_W-1:0]          quot;
    logic                      quot_sat;
    logic signed [SUM_W-1:0]   quot_val;
    logic signed [SUM_W-1:0]   new_term;
    logic signed [SUM_W:0]     new_sum;

    assign accept    = start && (state_reg == S_IDLE);
    assign angle_mag = angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;
    assign limit     = (int'(maxs_reg) > MAX_STEPS_LIMIT) ? STEP_W'(MAX_STEPS_LIMIT)
                                                          : STEP_W'(maxs_reg);
    assign diff      = {sum_reg[SUM_W-1], sum_reg} - {prev_reg[SUM_W-1], prev_reg};
    assign diff_mag  = diff[SUM_W] ? -diff : diff;
    assign go_on     = (diff_mag > {{(SUM_W + 1 - TOL_W){1'b0}}, tol_reg})
                       && (steps_reg < limit);
    assign k_new     = {STEP_W'(steps_reg + 1'b1), 1'b1};
    assign term_mag  = term_reg[SUM_W-1] ? MAG_W'(-term_reg) : MAG_W'(term_reg);
    assign sum_top   = sum_reg[SUM_W-1:SINE_W-1];
    assign quot      = mdu_result[DVD_W-1:0];
    assign quot_sat  = (|quot[DVD_W-1:CAP_BIT+1]) || (quot[CAP_BIT] && |quot[CAP_BIT-1:0]);
    assign quot_val  = quot_sat ? CAP_POS[SUM_W-1:0]
                                : {{(SUM_W - CAP_BIT - 1){1'b0}}, quot[CAP_BIT:0]};
    assign new_term  = term_reg[SUM_W-1] ? quot_val : -quot_val;
    assign new_sum   = {sum_reg[SUM_W-1], sum_reg} + {new_term[SUM_W-1], new_term};

    always_comb
    begin
        state_next = state_reg;
        tol_next   = tol_reg;
        maxs_next  = maxs_reg;
        sum_next   = sum_reg;
        prev_next  = prev_reg;
        term_next  = term_reg;
        x2_next    = x2_reg;
        steps_next = steps_reg;
        kk_next    = kk_reg;
        done_next  = 1'b0;
        sine_next  = sine_reg;
        terms_next = terms_reg;
        cmd.start  = 1'b0;
        cmd.op     = OP_MUL;
        mcand      = term_mag;
        mplier     = x2_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TOLERANCE: tol_next  = TOL_W'(cfg_data);
                REG_MAX_STEPS: maxs_next = cfg_data[MAXS_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sum_next   = SUM_W'(angle);
                    prev_next  = '0;
                    term_next  = SUM_W'(angle);
                    steps_next = '0;
                    cmd.start  = 1'b1;
                    mcand      = MAG_W'(angle_mag);
                    mplier     = X2_W'(angle_mag);
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                if (stat.done)
                begin
                    x2_next    = mdu_result[FRACTION_BITS +: X2_W];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (go_on)
                begin
                    prev_next  = sum_reg;
                    kk_next    = KK_W'(k_new) * KK_W'(k_new - 1'b1);
                    cmd.start  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    if ((&sum_top) || !(|sum_top))
                    begin
                        sine_next = sum_reg[SINE_W-1:0];
                    end
                    else
                    begin
                        sine_next = {sum_reg[SUM_W-1], {(SINE_W - 1){~sum_reg[SUM_W-1]}}};
                    end
                    terms_next = TERMS_W'(steps_reg + 1'b1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                if (stat.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.done)
                begin
                    term_next = new_term;
                    if (new_sum > CAP_POS)
                    begin
                        sum_next = CAP_POS[SUM_W-1:0];
                    end
                    else if (new_sum < CAP_NEG)
                    begin
                        sum_next = CAP_NEG[SUM_W-1:0];
                    end
                    else
                    begin
                        sum_next = new_sum[SUM_W-1:0];
                    end
                    steps_next = steps_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tol_reg   <= TOL_RESET;
            maxs_reg  <= MAXS_RESET;
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tol_reg   <= tol_next;
            maxs_reg  <= maxs_next;
            steps_reg <= steps_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        prev_reg  <= prev_next;
        term_reg  <= term_next;
        x2_reg    <= x2_next;
        kk_reg    <= kk_next;
        sine_reg  <= sine_next;
        terms_reg <= terms_next;
    end

    stsin_mdu u_mdu (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .mcand    (mcand),
        .mplier   (mplier),
        .dividend (mdu_result[FRACTION_BITS +: DVD_W]),
        .divisor  (kk_reg),
        .result   (mdu_result),
        .stat     (stat)
    );

    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign sine_value = sine_reg;
    assign terms_used = terms_reg;

    // shared unit is quiet whenever the sequencer is idle
    a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !stat.busy)
        else $error("arithmetic unit busy while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && stat.busy))
        else $error("accepted beat did not start work");

    a_terms_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((terms_used != '0) && (int'(terms_used) <= MAX_STEPS_LIMIT + 1)))
        else $error("terms_used out of range");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (steps_reg < limit))
        else $error("step taken beyond limit");

endmodule

`default_nettype wire

>>> hw/rtl/stsin_mdu.sv
// ----------------------------------------------------------------------------
// stsin_mdu
// Shared serial unit: shift-add multiply, one multiplier bit per cycle, or
// restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stsin_mdu (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire stsin_pkg::mdu_cmd_t          cmd,
    input  wire logic [stsin_pkg::MAG_W-1:0]  mcand,
    input  wire logic [stsin_pkg::X2_W-1:0]   mplier,
    input  wire logic [stsin_pkg::DVD_W-1:0]  dividend,
    input  wire logic [stsin_pkg::KK_W-1:0]   divisor,
    output logic      [stsin_pkg::PROD_W-1:0] result,
    output stsin_pkg::mdu_stat_t              stat
);
    import stsin_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              op_reg, op_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [X2_W-1:0]   mplier_reg, mplier_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [KK_W-1:0]   rem_reg, rem_next;
    logic [KK_W-1:0]   divisor_reg, divisor_next;

    logic [KK_W:0]     trial;
    logic [KK_W:0]     trial_sub;
    logic              trial_ge;
    logic              last;

    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_ge  = trial >= {1'b0, divisor_reg};
    assign trial_sub = trial - {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        last         = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = '0;
            if (cmd.op == OP_DIV)
            begin
                dvd_next     = dividend;
                rem_next     = '0;
                divisor_next = divisor;
            end
            else
            begin
                acc_next    = '0;
                mcand_next  = {{X2_W{1'b0}}, mcand};
                mplier_next = mplier;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                rem_next = trial_ge ? trial_sub[KK_W-1:0] : trial[KK_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], trial_ge};
                last     = (cnt_reg == CNT_W'(DVD_W - 1));
            end
            else
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                last        = (cnt_reg == CNT_W'(X2_W - 1));
            end
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign result    = (op_reg == OP_DIV) ? {{(PROD_W - DVD_W){1'b0}}, dvd_reg} : acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

>>> tb/sv/tb_sine_taylor_series_unit.sv
// ----------------------------------------------------------------------------
// tb_sine_taylor_series_unit
// Self-checking bench for the series sine unit. Angles go in through the
// start/busy handshake and each done beat is checked field by field against
// a bit-exact series predictor kept in a scoreboard. It steps the tolerance
// and step limit through several settings, including their extremes and
// spare register indexes, and varies how often the sender idles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sine_taylor_series_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import stsin_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    localparam int PI_Q      = 843314857;
    localparam int HALF_PI_Q = 421657428;

    localparam logic signed [65:0] SUM_CAP = 66'sd4611686018427387904;
    localparam logic signed [65:0] OUT_MAX = 66'sd549755813887;
    localparam logic signed [65:0] OUT_MIN = -66'sd549755813888;
    localparam logic [127:0]       Q_CAP   = 128'd1 << CAP_BIT;

    typedef struct {
        logic signed [SINE_W-1:0] sine;
        logic [TERMS_W-1:0]       terms;
    } sine_result_t;

    class sine_scoreboard;
        sine_result_t       sine_q[$];
        logic [TOL_W-1:0]   tolerance;
        logic [MAXS_W-1:0]  max_steps;
        int                 errors;

        function new();
            tolerance = TOL_RESET;
            max_steps = MAXS_RESET;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_TOLERANCE)
                tolerance = data[TOL_W-1:0];
            else if (idx == REG_MAX_STEPS)
                max_steps = data[MAXS_W-1:0];
        endfunction

        function logic [65:0] mag(logic signed [65:0] v);
            return (v < 0) ? -v : v;
        endfunction

        function void note_angle(logic signed [ANGLE_W-1:0] a);
            logic signed [65:0] x, sum, prev, term, mq;
            logic [63:0]        ax, x2;
            logic [127:0]       prod, dvs, quo;
            int unsigned        lim, steps, k;
            sine_result_t       res;
            x     = a;
            ax    = 64'(mag(x));
            x2    = (ax * ax) >> FRACTION_BITS;
            lim   = (max_steps > MAX_STEPS_LIMIT) ? MAX_STEPS_LIMIT : max_steps;
            sum   = x;
            prev  = '0;
            term  = x;
            steps = 0;
            k     = 1;
            while (mag(sum - prev) > {34'd0, tolerance} && steps < lim)
            begin
                prev = sum;
                k    = k + 2;
                dvs  = 128'(k * (k - 1)) << FRACTION_BITS;
                prod = {64'd0, 64'(mag(term))} * {64'd0, x2};
                quo  = prod / dvs;
                if (quo > Q_CAP)
                    quo = Q_CAP;
                mq   = $signed({2'b00, quo[63:0]});
                term = (term < 0) ? mq : -mq;
                sum  = sum + term;
                if (sum > SUM_CAP)
                    sum = SUM_CAP;
                if (sum < -SUM_CAP)
                    sum = -SUM_CAP;
                steps++;
            end
            if (sum > OUT_MAX)
                sum = OUT_MAX;
            if (sum < OUT_MIN)
                sum = OUT_MIN;
            res.sine  = sum[SINE_W-1:0];
            res.terms = TERMS_W'(steps + 1);
            sine_q.push_back(res);
        endfunction

        function void check_result(logic signed [SINE_W-1:0] s, logic [TERMS_W-1:0] t);
            sine_result_t exp_r;
            if (sine_q.size() == 0)
            begin
                $display("%0t: result beat with no angle pending: sine_value %0d terms_used %0d",
                         $time, s, t);
                errors++;
                return;
            end
            exp_r = sine_q.pop_front();
            if (s !== exp_r.sine)
            begin
                $display("%0t: sine_value mismatch: expected %0d actual %0d",
                         $time, exp_r.sine, s);
                errors++;
            end
            if (t !== exp_r.terms)
            begin
                $display("%0t: terms_used mismatch: expected %0d actual %0d",
                         $time, exp_r.terms, t);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [ANGLE_W-1:0]   angle;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        done;
    logic signed [SINE_W-1:0]    sine_value;
    logic [TERMS_W-1:0]          terms_used;

    sine_scoreboard sb;

    sine_taylor_series_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .angle      (angle),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .sine_value (sine_value),
        .terms_used (terms_used)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(sine_value, terms_used);
    end

    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        logic signed [ANGLE_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 2 * PI_Q)) - PI_Q;
            2: v = 32'($urandom_range(0, 2097152)) - 32'sd1048576;
            default:
            begin
                v = 32'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic send_angle(input logic signed [ANGLE_W-1:0] a, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        angle <= a;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_angle(a);
    endtask

    task automatic run_random(input int count, input int idle_pct);
        repeat (count)
            send_angle(rand_angle(), idle_pct);
    endtask

    // waits for the unit to drain before touching a register
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        start <= 1'b0;
        while (sb.sine_q.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic signed [ANGLE_W-1:0] corner[$];
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        angle     = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        corner = '{32'sd0, 32'sd1, -32'sd1, 32'sd268, 32'sd269, -32'sd269,
                   32'sh1000_0000, -32'sh1000_0000, HALF_PI_Q, -HALF_PI_Q,
                   PI_Q, -PI_Q, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_0000, 32'sh3000_0000};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner[i])
            send_angle(corner[i], 0);

        write_cfg(REG_TOLERANCE, 32'd0);
        write_cfg(REG_MAX_STEPS, 32'd32);
        run_random(15, 67);

        write_cfg(REG_SPARE_A, $urandom);
        write_cfg(REG_TOLERANCE, 32'hFFFF_FFFF);
        write_cfg(REG_MAX_STEPS, 32'd0);
        foreach (corner[i])
            send_angle(corner[i], 0);
        run_random(60, 13);

        // upper data bits set, step limit above range
        write_cfg(REG_TOLERANCE, 32'($urandom_range(0, 65535)));
        write_cfg(REG_MAX_STEPS, 32'hFFFF_FFE5);
        write_cfg(REG_SPARE_B, $urandom);
        run_random(30, 0);

        write_cfg(REG_TOLERANCE, 32'd268);
        write_cfg(REG_MAX_STEPS, 32'd10);
        run_random(130, 67);

        write_cfg(REG_TOLERANCE, 32'd1 << 20);
        write_cfg(REG_MAX_STEPS, 32'd5);
        run_random(100, 13);

        write_cfg(REG_TOLERANCE, 32'd1);
        write_cfg(REG_MAX_STEPS, 32'd63);
        run_random(25, 0);

        start <= 1'b0;
        while (sb.sine_q.size() != 0)
            @(posedge clk);
        repeat (4000) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_sine_taylor_series_unit: clean");
        else
            $display("tb_sine_taylor_series_unit: errors");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("tb_sine_taylor_series_unit: errors");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/stsin_pkg.sv
hw/rtl/stsin_mdu.sv
hw/rtl/sine_taylor_series_unit.sv
tb/sv/tb_sine_taylor_series_unit.sv
